@@ sv/ssrc_pkg.sv @@
// Package for the sorted store range counter.
// Holds the word types of both channels, default sizes and the cell control group.
// No dependencies.
package ssrc_pkg;

	localparam int unsigned SSRC_CAPACITY   = 256;
	localparam int unsigned SSRC_VALUE_BITS = 32;
	localparam int unsigned SSRC_COUNT_BITS = 9;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_QUERY  = 1'b1
	} ssrc_action_t;

	typedef struct packed {
		ssrc_action_t       action;
		logic signed [31:0] value;
		logic signed [31:0] low_a;
		logic signed [31:0] high_a;
		logic signed [31:0] low_b;
		logic signed [31:0] high_b;
	} ssrc_item_t;

	typedef struct packed {
		logic [SSRC_COUNT_BITS-1:0] count;
		logic                       dropped_insert;
	} ssrc_result_t;

	// Per-cell control from the fill counter.
	typedef struct packed {
		logic ins;       // insert word accepted and store not full
		logic occupied;  // cell index below fill count
		logic at_end;    // cell index equals fill count
	} ssrc_cell_ctrl_t;

endpackage

@@ sv/sorted_store_range_count.sv @@
// Sorted store with a two-interval range count. A word is taken in every cycle (busy stays
// low). An insert shifts the chain of CAPACITY cells in place at the accepting edge. A query
// compares every cell against both intervals at the accepting edge and counts the hits in a
// registered adder tree; its result word comes on result with done high for one cycle,
// once the query has passed the leaf register and every level of the tree.
// Results leave in query order and cannot be held off. Inserts give no result.
// Depends on ssrc_pkg, ssrc_cell, ssrc_count_tree.
module sorted_store_range_count import ssrc_pkg::*; #(
	parameter int unsigned CAPACITY   = SSRC_CAPACITY,
	parameter int unsigned VALUE_BITS = SSRC_VALUE_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  ssrc_item_t   item,
	output logic         done,
	output ssrc_result_t result
);

	localparam int unsigned CNTW = $clog2(CAPACITY + 1);

	function automatic logic signed [VALUE_BITS-1:0] to_key(input logic [31:0] f);
		logic [63:0] x;
		x = {{32{f[31]}}, f};
		return x[VALUE_BITS-1:0];
	endfunction

	logic [CNTW-1:0] count_q;
	logic            overflow_q;
	logic            accept;
	logic            ins_ok;
	logic            query;
	logic            full;

	logic signed [VALUE_BITS-1:0] key;
	logic signed [VALUE_BITS-1:0] la;
	logic signed [VALUE_BITS-1:0] ha;
	logic signed [VALUE_BITS-1:0] lb;
	logic signed [VALUE_BITS-1:0] hb;

	logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
	logic [CAPACITY-1:0]          cell_gt;
	logic [CAPACITY-1:0]          cell_hit;

	logic            tree_valid;
	logic            tree_tag;
	logic [CNTW-1:0] tree_total;
	logic [CNTW+8:0] total_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNTW'(CAPACITY));
	assign ins_ok = accept && (item.action == ACT_INSERT) && !full;
	assign query  = accept && (item.action == ACT_QUERY);

	assign key = to_key(item.value);
	assign la  = to_key(item.low_a);
	assign ha  = to_key(item.high_a);
	assign lb  = to_key(item.low_b);
	assign hb  = to_key(item.high_b);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssrc_cell_ctrl_t ctrl;
		logic signed [VALUE_BITS-1:0] prev_value;
		logic prev_gt;

		assign ctrl.ins      = ins_ok;
		assign ctrl.occupied = (CNTW'(i) < count_q);
		assign ctrl.at_end   = (CNTW'(i) == count_q);

		if (i == 0) begin : g_head
			assign prev_value = key;
			assign prev_gt    = 1'b0;
		end else begin : g_link
			assign prev_value = cell_value[i-1];
			assign prev_gt    = cell_gt[i-1];
		end

		ssrc_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key       (key),
			.prev_value(prev_value),
			.prev_gt   (prev_gt),
			.low_a     (la),
			.high_a    (ha),
			.low_b     (lb),
			.high_b    (hb),
			.value_q   (cell_value[i]),
			.gt        (cell_gt[i]),
			.hit       (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			if (ins_ok) begin
				count_q <= count_q + CNTW'(1);
			end
			// drop an insert into a full store, remember it
			if (accept && (item.action == ACT_INSERT) && full) begin
				overflow_q <= 1'b1;
			end
		end
	end

	ssrc_count_tree #(
		.CAPACITY(CAPACITY)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (query),
		.in_tag   (overflow_q),
		.hit      (cell_hit),
		.out_valid(tree_valid),
		.out_tag  (tree_tag),
		.total    (tree_total)
	);

	assign total_ext             = {9'b0, tree_total};
	assign done                  = tree_valid;
	assign result.count          = total_ext[8:0];
	assign result.dropped_insert = tree_tag;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (count_q == $past(count_q) + CNTW'(1)))
		else $error("fill count did not advance on insert");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(CAPACITY))
		else $error("fill count above capacity");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("drop flag cleared");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.action == ACT_INSERT) && full) |=> (overflow_q && $stable(count_q)))
		else $error("insert into full store not dropped");

	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((CAPACITY > 511) || (tree_total <= CNTW'(CAPACITY))))
		else $error("range count above capacity");

endmodule

@@ sv/ssrc_cell.sv @@
// One cell of the sorted chain: holds one value, shifts up on insert, flags query hits.
// Depends on ssrc_pkg.
module ssrc_cell import ssrc_pkg::*; #(
	parameter int unsigned VALUE_BITS = SSRC_VALUE_BITS
) (
	input  logic                         clk,
	input  ssrc_cell_ctrl_t              ctrl,
	input  logic signed [VALUE_BITS-1:0] key,
	input  logic signed [VALUE_BITS-1:0] prev_value,
	input  logic                         prev_gt,
	input  logic signed [VALUE_BITS-1:0] low_a,
	input  logic signed [VALUE_BITS-1:0] high_a,
	input  logic signed [VALUE_BITS-1:0] low_b,
	input  logic signed [VALUE_BITS-1:0] high_b,
	output logic signed [VALUE_BITS-1:0] value_q,
	output logic                         gt,
	output logic                         hit
);

	logic take;
	logic in_a;
	logic in_b;

	assign gt   = ctrl.occupied && (value_q > key);
	// The new key lands at the first cell above it; cells past it take the lower neighbor.
	assign take = gt || ctrl.at_end;
	assign in_a = (low_a <= value_q) && (value_q <= high_a);
	assign in_b = (low_b <= value_q) && (value_q <= high_b);
	assign hit  = ctrl.occupied && (in_a || in_b);

	always_ff @(posedge clk) begin
		if (ctrl.ins && take) begin
			value_q <= prev_gt ? prev_value : key;
		end
	end

endmodule

@@ sv/ssrc_count_tree.sv @@
// Registered adder tree that counts the hit flags of all cells, with a register at each level.
// Carries a valid bit and a one-bit tag alongside. Depends on ssrc_pkg.
module ssrc_count_tree import ssrc_pkg::*; #(
	parameter int unsigned CAPACITY = SSRC_CAPACITY,
	localparam int unsigned CW      = $clog2(CAPACITY + 1),
	localparam int unsigned LEVELS  = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_tag,
	input  logic [CAPACITY-1:0] hit,
	output logic                out_valid,
	output logic                out_tag,
	output logic [CW-1:0]       total
);

	localparam int unsigned LEAVES = 1 << LEVELS;
	localparam int unsigned NODES  = 2 * LEAVES - 1;

	logic [CW-1:0] node_q [NODES];
	logic [LEVELS:0] vld_q;
	logic [LEVELS:0] tag_q;

	for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
		if (k < CAPACITY) begin : g_used
			always_ff @(posedge clk) begin
				node_q[LEAVES-1+k] <= CW'(hit[k]);
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				node_q[LEAVES-1+k] <= '0;
			end
		end
	end

	for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
		always_ff @(posedge clk) begin
			node_q[k] <= node_q[2*k+1] + node_q[2*k+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LEVELS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		tag_q <= {tag_q[LEVELS-1:0], in_tag};
	end

	assign out_valid = vld_q[LEVELS];
	assign out_tag   = tag_q[LEVELS];
	assign total     = node_q[0];

endmodule

@@ tb/sorted_store_range_count_tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_store_range_count: inserts and two-interval range count queries.
// A scoreboard class keeps a sorted shadow store and predicts each query's count word.
// Depends on ssrc_pkg and sorted_store_range_count.
module sorted_store_range_count_tb;
	import ssrc_pkg::*;

	localparam int VMIN = 32'sh8000_0000;
	localparam int VMAX = 32'sh7fff_ffff;
	localparam int RANDOM_WORDS = 1130;

	// Shadow of the sorted store plus the queue of predicted query results.
	class sorted_store_shadow;
		int values[$];
		int unsigned fill_limit;
		bit overflow_seen;
		ssrc_result_t pending_counts[$];
		int errors;

		function new(int unsigned cap);
			fill_limit = cap;
			overflow_seen = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// A value counts once if it lies in either non-empty interval.
		function int unsigned union_count(int la, int ha, int lb, int hb);
			bit a_ok;
			bit b_ok;
			int unsigned n;
			a_ok = la <= ha;
			b_ok = lb <= hb;
			n = 0;
			foreach (values[i]) begin
				if ((a_ok && values[i] >= la && values[i] <= ha) ||
				    (b_ok && values[i] >= lb && values[i] <= hb))
					n++;
			end
			return n;
		endfunction

		function void note_word(ssrc_item_t w);
			ssrc_result_t r;
			int pos;
			if (w.action == ACT_INSERT) begin
				// drop the insert once full
				if (values.size() >= fill_limit) begin
					overflow_seen = 1'b1;
					return;
				end
				pos = 0;
				while (pos < values.size() && values[pos] <= int'(w.value))
					pos++;
				values.insert(pos, int'(w.value));
			end else begin
				r.count = SSRC_COUNT_BITS'(union_count(w.low_a, w.high_a, w.low_b, w.high_b));
				r.dropped_insert = overflow_seen;
				pending_counts.push_back(r);
			end
		endfunction

		task check_word(ssrc_result_t got);
			ssrc_result_t want;
			if (pending_counts.size() == 0) begin
				report($sformatf("result word with no query waiting, count %0d", got.count));
				return;
			end
			want = pending_counts.pop_front();
			if (got.count !== want.count)
				report($sformatf("count %0d, expected %0d", got.count, want.count));
			if (got.dropped_insert !== want.dropped_insert)
				report($sformatf("dropped_insert %b, expected %b",
					got.dropped_insert, want.dropped_insert));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	ssrc_item_t   item;
	logic         done;
	ssrc_result_t result;

	sorted_store_shadow board;

	sorted_store_range_count dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("sorted_store_range_count verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_word(result);
	end

	function automatic ssrc_item_t mk_insert(int v);
		ssrc_item_t w;
		w.action = ACT_INSERT;
		w.value  = v;
		w.low_a  = $urandom;
		w.high_a = $urandom;
		w.low_b  = $urandom;
		w.high_b = $urandom;
		return w;
	endfunction

	function automatic ssrc_item_t mk_query(int la, int ha, int lb, int hb);
		ssrc_item_t w;
		w.action = ACT_QUERY;
		w.value  = $urandom;
		w.low_a  = la;
		w.high_a = ha;
		w.low_b  = lb;
		w.high_b = hb;
		return w;
	endfunction

	// Small values for duplicates in three of ten, edges in one, the rest anywhere.
	function automatic int rand_value();
		case ($urandom_range(0, 9))
			0, 1, 2: return int'($urandom_range(0, 40)) - 20;
			3: begin
				case ($urandom_range(0, 5))
					0: return VMIN;
					1: return VMIN + 1;
					2: return -1;
					3: return 0;
					4: return VMAX - 1;
					default: return VMAX;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Bounds near stored values make the edges of each interval matter.
	function automatic int rand_bound();
		int n;
		n = board.values.size();
		if (n != 0 && $urandom_range(0, 1) == 1)
			return board.values[$urandom_range(0, n - 1)] + (int'($urandom_range(0, 2)) - 1);
		return rand_value();
	endfunction

	function automatic void rand_interval(output int lo, output int hi);
		int x;
		int y;
		x = rand_bound();
		y = rand_bound();
		// leave about one in five reversed so empty intervals show up
		if (($urandom_range(0, 4) != 0) == (x <= y)) begin
			lo = x;
			hi = y;
		end else begin
			lo = y;
			hi = x;
		end
	endfunction

	function automatic ssrc_item_t rand_word();
		int la;
		int ha;
		int lb;
		int hb;
		if ($urandom_range(0, 99) < 35)
			return mk_insert(rand_value());
		rand_interval(la, ha);
		rand_interval(lb, hb);
		case ($urandom_range(0, 9))
			0: begin
				la = VMIN;
				ha = VMAX;
			end
			1: lb = ha;
			2: lb = ha + 1;
			default: ;
		endcase
		return mk_query(la, ha, lb, hb);
	endfunction

	task send_word(ssrc_item_t w);
		@(negedge clk);
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		board.note_word(w);
	endtask

	task idle(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	initial begin
		int sent;
		int burst;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		board  = new(SSRC_CAPACITY);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle(2);

		// empty store, then edge values and duplicates
		send_word(mk_query(VMIN, VMAX, VMIN, VMAX));
		send_word(mk_insert(VMIN));
		send_word(mk_insert(VMAX));
		send_word(mk_insert(0));
		idle(3);
		send_word(mk_insert(-1));
		send_word(mk_insert(1));
		send_word(mk_insert(5));
		send_word(mk_insert(5));
		send_word(mk_insert(5));
		send_word(mk_insert(VMIN));
		idle(1);
		// empty intervals, disjoint, overlapping, touching, nested
		send_word(mk_query(VMIN, VMAX, 1, 0));
		send_word(mk_query(5, 5, VMAX, VMIN));
		send_word(mk_query(0, -1, VMIN, VMIN));
		send_word(mk_query(VMAX, VMIN, 7, 6));
		idle(4);
		send_word(mk_query(VMIN, -1, 1, VMAX));
		send_word(mk_query(-1, 5, 0, VMAX));
		send_word(mk_query(-1, 0, 0, 1));
		send_word(mk_query(VMAX, VMAX, VMIN, VMIN));
		idle(2);
		send_word(mk_query(0, 5, 0, 5));
		send_word(mk_query(VMIN, VMAX, 0, 0));

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			repeat (burst) begin
				send_word(rand_word());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 10));
		end
		idle(1);

		while (board.pending_counts.size() != 0)
			@(posedge clk);
		repeat (2 * $clog2(SSRC_CAPACITY)) @(posedge clk);

		if (board.errors == 0)
			$display("sorted_store_range_count verification clean");
		else
			$display("sorted_store_range_count verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/ssrc_pkg.sv
sv/ssrc_cell.sv
sv/ssrc_count_tree.sv
sv/sorted_store_range_count.sv
tb/sorted_store_range_count_tb.sv
